// ----- sv/pexalu_pkg.sv -----
// Shared types and opcode constants for the execute stage.
// No dependencies; used by the top level, pexalu_fwd and pexalu_alu.
package pexalu_pkg;

    // Primary opcodes.
    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_JAL   = 6'h03;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_SLTI  = 6'h0A;
    localparam logic [5:0] OP_ANDI  = 6'h0C;
    localparam logic [5:0] OP_ORI   = 6'h0D;
    localparam logic [5:0] OP_XORI  = 6'h0E;
    localparam logic [5:0] OP_LUI   = 6'h0F;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2B;

    // R-format function codes.
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2A;

    // Operand source selects.
    localparam logic [1:0] FWD_RF   = 2'd0;
    localparam logic [1:0] FWD_WB   = 2'd1;
    localparam logic [1:0] FWD_PREV = 2'd2;

    // Destinations of the two instructions ahead, for the forwarding unit.
    typedef struct packed {
        logic       prev_writes;
        logic [4:0] prev_dest;
        logic       older_writes;
        logic [4:0] older_dest;
    } t_fwd_state;

    // What the ALU reports besides its result.
    typedef struct packed {
        logic [31:0] result;
        logic        branch_upd;
        logic        branch_val;
        logic        syscall;
        logic        unimpl;
    } t_alu_out;

endpackage

// ----- sv/pipeline_execute_stage_alu_forwarding_top.sv -----
// Top level of the execute stage: input register, forwarding, ALU, result
// register and the stage state. Depends on pexalu_pkg, pexalu_fwd, pexalu_alu.
//
//  channel  | valid   | ready   | payload
//  ---------+---------+---------+------------------------------------------
//  input    | i_valid | o_ready | i_opcode .. i_wb_write_data
//  result   | o_valid | i_ready | o_exe_result .. o_forward_b_sel
//
// One item per cycle sustained while i_ready stays high. An accepted item is
// captured in the input register, passes through the forwarding unit and the
// ALU, and is offered as a result from the result register; the forwarding
// state is updated at the same edge as the result register.
// Reset (i_rst_n low, synchronous) empties both registers and clears state.
// A stalled result holds the result register; the input register then fills
// and o_ready drops until i_ready returns.
module pipeline_execute_stage_alu_forwarding_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [5:0]  i_opcode,
    input  logic [5:0]  i_funct,
    input  logic [4:0]  i_shamt,
    input  logic [4:0]  i_dest_reg,
    input  logic [4:0]  i_src_reg_a,
    input  logic [4:0]  i_src_reg_b,
    input  logic [31:0] i_read_data_a,
    input  logic [31:0] i_read_data_b,
    input  logic [31:0] i_immediate,
    input  logic        i_use_immediate,
    input  logic        i_writes_register,
    input  logic [31:0] i_wb_write_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_exe_result,
    output logic [31:0] o_store_data,
    output logic [4:0]  o_dest_out,
    output logic        o_writes_out,
    output logic        o_branch_taken,
    output logic        o_is_syscall,
    output logic        o_unimplemented,
    output logic [1:0]  o_forward_a_sel,
    output logic [1:0]  o_forward_b_sel
);

    // Input register.
    logic        r_in_valid;
    logic [5:0]  r_opcode;
    logic [5:0]  r_funct;
    logic [4:0]  r_shamt;
    logic [4:0]  r_dest;
    logic [4:0]  r_src_a;
    logic [4:0]  r_src_b;
    logic [31:0] r_rd_a;
    logic [31:0] r_rd_b;
    logic [31:0] r_imm;
    logic        r_use_imm;
    logic        r_writes;
    logic [31:0] r_wb_data;

    // Stage state.
    pexalu_pkg::t_fwd_state r_fwd;
    logic [31:0]            r_prev_result;
    logic                   r_branch_flag;

    // Result register.
    logic        r_out_valid;
    logic [31:0] r_exe_result;
    logic [31:0] r_store_data;
    logic [4:0]  r_dest_out;
    logic        r_writes_out;
    logic        r_branch_taken;
    logic        r_is_syscall;
    logic        r_unimpl;
    logic [1:0]  r_sel_a;
    logic [1:0]  r_sel_b;

    logic                 advance;
    logic                 accept;
    logic [1:0]           sel_a;
    logic [1:0]           sel_b;
    logic [31:0]          op_a;
    logic [31:0]          fwd_b;
    logic [31:0]          op_b;
    logic                 n_branch_flag;
    pexalu_pkg::t_alu_out alu_out;

    // Handshake: the item moves on when the result register is free or drains.
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign accept  = i_valid && o_ready;

    pexalu_fwd u_fwd (
        .i_state       (r_fwd),
        .i_prev_result (r_prev_result),
        .i_src_a       (r_src_a),
        .i_src_b       (r_src_b),
        .i_rd_a        (r_rd_a),
        .i_rd_b        (r_rd_b),
        .i_wb_data     (r_wb_data),
        .o_sel_a       (sel_a),
        .o_sel_b       (sel_b),
        .o_op_a        (op_a),
        .o_op_b        (fwd_b)
    );

    assign op_b = r_use_imm ? r_imm : fwd_b;

    pexalu_alu u_alu (
        .i_opcode      (r_opcode),
        .i_funct       (r_funct),
        .i_shamt       (r_shamt),
        .i_dest        (r_dest),
        .i_a           (op_a),
        .i_b           (op_b),
        .i_prev_result (r_prev_result),
        .o_out         (alu_out)
    );

    assign n_branch_flag = alu_out.branch_upd ? alu_out.branch_val : r_branch_flag;

    // Valid flags and stage state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_fwd         <= '0;
            r_prev_result <= 32'd0;
            r_branch_flag <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid        <= 1'b1;
                r_fwd.older_writes <= r_fwd.prev_writes;
                r_fwd.older_dest   <= r_fwd.prev_dest;
                r_fwd.prev_writes  <= r_writes;
                r_fwd.prev_dest    <= r_dest;
                r_prev_result      <= alu_out.result;
                r_branch_flag      <= n_branch_flag;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Input payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_opcode  <= i_opcode;
            r_funct   <= i_funct;
            r_shamt   <= i_shamt;
            r_dest    <= i_dest_reg;
            r_src_a   <= i_src_reg_a;
            r_src_b   <= i_src_reg_b;
            r_rd_a    <= i_read_data_a;
            r_rd_b    <= i_read_data_b;
            r_imm     <= i_immediate;
            r_use_imm <= i_use_immediate;
            r_writes  <= i_writes_register;
            r_wb_data <= i_wb_write_data;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_exe_result   <= alu_out.result;
            r_store_data   <= fwd_b;
            r_dest_out     <= r_dest;
            r_writes_out   <= r_writes;
            r_branch_taken <= n_branch_flag;
            r_is_syscall   <= alu_out.syscall;
            r_unimpl       <= alu_out.unimpl;
            r_sel_a        <= sel_a;
            r_sel_b        <= sel_b;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_exe_result    = r_exe_result;
    assign o_store_data    = r_store_data;
    assign o_dest_out      = r_dest_out;
    assign o_writes_out    = r_writes_out;
    assign o_branch_taken  = r_branch_taken;
    assign o_is_syscall    = r_is_syscall;
    assign o_unimplemented = r_unimpl;
    assign o_forward_a_sel = r_sel_a;
    assign o_forward_b_sel = r_sel_b;

endmodule

// ----- sv/pexalu_fwd.sv -----
// Operand forwarding unit: picks each source operand from the register file,
// the writeback value or the previous result. Depends on pexalu_pkg.
module pexalu_fwd (
    input  pexalu_pkg::t_fwd_state i_state,
    input  logic [31:0]            i_prev_result,
    input  logic [4:0]             i_src_a,
    input  logic [4:0]             i_src_b,
    input  logic [31:0]            i_rd_a,
    input  logic [31:0]            i_rd_b,
    input  logic [31:0]            i_wb_data,
    output logic [1:0]             o_sel_a,
    output logic [1:0]             o_sel_b,
    output logic [31:0]            o_op_a,
    output logic [31:0]            o_op_b
);

    // The previous instruction wins; the older one only applies when the
    // previous destination differs, whether or not it writes.
    function automatic logic [1:0] pick(input pexalu_pkg::t_fwd_state st,
                                        input logic [4:0] src);
        logic [1:0] sel;
        sel = pexalu_pkg::FWD_RF;
        if (st.prev_writes && st.prev_dest != 5'd0 && st.prev_dest == src) begin
            sel = pexalu_pkg::FWD_PREV;
        end else if (st.older_writes && st.older_dest != 5'd0 &&
                     st.prev_dest != src && st.older_dest == src) begin
            sel = pexalu_pkg::FWD_WB;
        end
        return sel;
    endfunction

    assign o_sel_a = pick(i_state, i_src_a);
    assign o_sel_b = pick(i_state, i_src_b);

    // Operand muxes.
    always_comb begin
        case (o_sel_a)
            pexalu_pkg::FWD_PREV: o_op_a = i_prev_result;
            pexalu_pkg::FWD_WB:   o_op_a = i_wb_data;
            default:              o_op_a = i_rd_a;
        endcase
        case (o_sel_b)
            pexalu_pkg::FWD_PREV: o_op_b = i_prev_result;
            pexalu_pkg::FWD_WB:   o_op_b = i_wb_data;
            default:              o_op_b = i_rd_b;
        endcase
    end

endmodule

// ----- sv/pexalu_alu.sv -----
// ALU with opcode and funct decode, branch compare and status marks.
// Depends on pexalu_pkg.
module pexalu_alu (
    input  logic [5:0]           i_opcode,
    input  logic [5:0]           i_funct,
    input  logic [4:0]           i_shamt,
    input  logic [4:0]           i_dest,
    input  logic [31:0]          i_a,
    input  logic [31:0]          i_b,
    input  logic [31:0]          i_prev_result,
    output pexalu_pkg::t_alu_out o_out
);

    logic [31:0] diff;
    logic [31:0] sum;
    logic        less;

    assign diff = i_a - i_b;
    assign sum  = i_a + i_b;
    assign less = $signed(i_a) < $signed(i_b);

    // Decode. Ops that compute nothing repeat the previous result.
    always_comb begin
        o_out.result     = i_prev_result;
        o_out.branch_upd = 1'b0;
        o_out.branch_val = 1'b0;
        o_out.syscall    = 1'b0;
        o_out.unimpl     = 1'b0;
        if (i_opcode == pexalu_pkg::OP_RTYPE) begin
            unique case (i_funct) inside
                pexalu_pkg::FN_ADD, pexalu_pkg::FN_ADDU: o_out.result = sum;
                pexalu_pkg::FN_SUB: o_out.result = diff;
                pexalu_pkg::FN_AND: o_out.result = i_a & i_b;
                pexalu_pkg::FN_OR:  o_out.result = i_a | i_b;
                pexalu_pkg::FN_XOR: o_out.result = i_a ^ i_b;
                pexalu_pkg::FN_NOR: o_out.result = ~(i_a | i_b);
                pexalu_pkg::FN_SLT: o_out.result = {31'd0, less};
                pexalu_pkg::FN_SLL: begin
                    // A shift into register zero is the nop.
                    if (i_dest != 5'd0) begin
                        o_out.result = i_b << i_shamt;
                    end
                end
                pexalu_pkg::FN_SRL: o_out.result = i_b >> i_shamt;
                pexalu_pkg::FN_SRA: o_out.result = $unsigned($signed(i_b) >>> i_shamt);
                pexalu_pkg::FN_JR: begin
                end
                pexalu_pkg::FN_SYSCALL: o_out.syscall = 1'b1;
                default: o_out.unimpl = 1'b1;
            endcase
        end else begin
            unique case (i_opcode) inside
                pexalu_pkg::OP_ADDI, pexalu_pkg::OP_LW, pexalu_pkg::OP_SW:
                    o_out.result = sum;
                pexalu_pkg::OP_ANDI: o_out.result = i_a & i_b;
                pexalu_pkg::OP_ORI:  o_out.result = i_a | i_b;
                pexalu_pkg::OP_XORI: o_out.result = i_a ^ i_b;
                pexalu_pkg::OP_SLTI: o_out.result = {31'd0, less};
                pexalu_pkg::OP_LUI:  o_out.result = {i_b[15:0], 16'd0};
                pexalu_pkg::OP_BEQ: begin
                    o_out.result     = diff;
                    o_out.branch_upd = 1'b1;
                    o_out.branch_val = (diff == 32'd0);
                end
                pexalu_pkg::OP_BNE: begin
                    o_out.result     = diff;
                    o_out.branch_upd = 1'b1;
                    o_out.branch_val = (diff != 32'd0);
                end
                pexalu_pkg::OP_J, pexalu_pkg::OP_JAL: begin
                end
                default: o_out.unimpl = 1'b1;
            endcase
        end
    end

endmodule

// ----- sv/pexalu_chk.sv -----
// Port-level checks for the execute stage, bound to the top level.
// Depends on pipeline_execute_stage_alu_forwarding_top.
module pexalu_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_exe_result,
    input logic        o_is_syscall,
    input logic        o_unimplemented,
    input logic [1:0]  o_forward_a_sel,
    input logic [1:0]  o_forward_b_sel
);

    // A held result keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_exe_result))
        else $error("result changed while stalled");

    // The input side only stalls behind a full, stalled result register.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled without a stalled result");

    // Reset empties the stage.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("stage not empty after reset");

    // Syscall is a handled code, and no select uses the spare code.
    a_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_is_syscall && o_unimplemented) &&
        o_forward_a_sel != 2'd3 && o_forward_b_sel != 2'd3)
        else $error("inconsistent status marks");

endmodule

bind pipeline_execute_stage_alu_forwarding_top pexalu_chk u_pexalu_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_exe_result    (o_exe_result),
    .o_is_syscall    (o_is_syscall),
    .o_unimplemented (o_unimplemented),
    .o_forward_a_sel (o_forward_a_sel),
    .o_forward_b_sel (o_forward_b_sel)
);
